@@ hdl/cme_pkg.sv @@
// Shared constants, types and helpers of the cell motion energy block.
package cme_pkg;

   localparam int GRID_W    = 16;
   localparam int GRID_H    = 12;
   localparam int CELL_SIDE = 8;
   localparam int MAX_DIM   = 4096;

   localparam int LW     = GRID_W * CELL_SIDE;
   localparam int LH     = GRID_H * CELL_SIDE;
   localparam int NCELLS = GRID_W * GRID_H;
   localparam int AREA   = CELL_SIDE * CELL_SIDE;

   localparam int CH_W      = 8;
   localparam int DIM_W     = 13;
   localparam int POS_W     = 12;
   localparam int ACC_W     = 12;
   localparam int CX_W      = $clog2(LW);
   localparam int CY_W      = $clog2(LH + 1);
   localparam int CSUB_W    = $clog2(CELL_SIDE);
   localparam int CELL_W    = $clog2(GRID_W);
   localparam int IDX_W     = 8;
   localparam int LUMA_W    = 16;
   localparam int EN_W      = 16;
   localparam int SUM_W     = 28;
   localparam int CNT_W     = 11;
   localparam int BE_W      = 22;
   localparam int FSUM_W    = 24;
   localparam int DIVN_W    = 28;
   localparam int STEP_W    = $clog2(DIVN_W + 1);
   localparam int PREV_AW   = $clog2(LW * LH);
   localparam int CSR_IDX_W = 2;

   // The frame mean divides by NCELLS = 3 << FMEAN_SH: a shift, then a multiplication
   // by the reciprocal of three, exact for every shifted sum of FHI_W bits.
   localparam int FMEAN_SH    = 6;
   localparam int FHI_W       = FSUM_W - FMEAN_SH;
   localparam int FPROD_W     = 2 * FHI_W;
   localparam int THIRD_SHIFT = 19;
   localparam logic [FHI_W-1:0] THIRD_RECIP = 18'd174763;

   localparam logic [LUMA_W-1:0] W_RED   = 16'd77;
   localparam logic [LUMA_W-1:0] W_GREEN = 16'd150;
   localparam logic [LUMA_W-1:0] W_BLUE  = 16'd29;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd448;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef struct packed {
      logic accept;
      logic acc_write;
      logic x_step;
      logic y_step;
      logic fin_read;
      logic div_row_start;
      logic fin_write;
      logic band_read;
      logic band_commit;
      logic frame_load;
      logic row_commit;
   } cme_cmd_type;

   typedef struct packed {
      logic row_end;
      logic last_row;
      logic x_fold_more;
      logic x_more;
      logic y_fold_more;
      logic y_more;
      logic fin_needed;
      logic cnt_zero;
      logic div_busy;
      logic div_done;
      logic col_last;
      logic band_end;
      logic g_last;
      logic emit_band;
      logic c_last;
      logic frame_out;
      logic out_free;
   } cme_stat_type;

   // A dimension of zero counts as one, and anything above the maximum is clipped.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

endpackage

@@ hdl/cme_div.sv @@
// Restoring bit-serial divider, one quotient bit per cycle.
module cme_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cme_pkg::DIVN_W-1:0]  num,
   input  logic [cme_pkg::CNT_W-1:0]   den,
   output logic                        busy,
   output logic                        done,
   output logic [cme_pkg::DIVN_W-1:0]  quo
);
   import cme_pkg::*;

   logic [DIVN_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic              ge;

   assign trial = {rem_ff, quo_ff[DIVN_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         step_in = STEP_W'(DIVN_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVN_W-2:0], ge};
         rem_in  = ge ? CNT_W'(trial - {1'b0, den_ff}) : CNT_W'(trial);
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ hdl/cme_datapath.sv @@
// Datapath: position tracking, column sums, grid store, cell energies and result register.
module cme_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  cme_pkg::cme_cmd_type            cmd,
   output cme_pkg::cme_stat_type           stat,
   input  logic [cme_pkg::CH_W-1:0]        req_red,
   input  logic [cme_pkg::CH_W-1:0]        req_green,
   input  logic [cme_pkg::CH_W-1:0]        req_blue,
   input  logic                            csr_write,
   input  logic [cme_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cme_pkg::DIM_W-1:0]       csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [cme_pkg::IDX_W-1:0]       rsp_cell_index,
   output logic [cme_pkg::EN_W-1:0]        rsp_energy,
   output logic                            rsp_last
);
   import cme_pkg::*;

   // Configuration and position state.
   logic [DIM_W-1:0]  width_ff, width_in, height_ff, height_in;
   logic [POS_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [CX_W-1:0]   cx_ff, cx_in, gcol_ff, gcol_in;
   logic [ACC_W-1:0]  accx_ff, accx_in, accy_ff, accy_in, nacc_ff, nacc_in;
   logic [CY_W-1:0]   cy_ff, cy_in, gnext_ff, gnext_in, g_ff, g_in;
   logic [CELL_W-1:0] c_ff, c_in;
   logic              fe_ff, fe_in, have_prev_ff, have_prev_in;
   logic [FSUM_W-1:0] frame_sum_ff, frame_sum_in;
   logic [LW-1:0]     row_vld_ff, row_vld_in;
   logic [GRID_W-1:0] band_vld_ff, band_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              restart;

   // Payload registers.
   logic [LUMA_W-1:0] luma_ff;
   logic              rsp_kind_ff, rsp_last_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [EN_W-1:0]   rsp_energy_ff;

   // Memories.
   logic [SUM_W+CNT_W-1:0] row_mem [LW];
   logic [LUMA_W-1:0]      prev_mem [LW*LH];
   logic [BE_W-1:0]        band_mem [GRID_W];
   logic [SUM_W+CNT_W-1:0] row_rd_ff;
   logic                   row_rd_vld_ff;
   logic [LUMA_W-1:0]      prev_rd_ff;
   logic [BE_W-1:0]        band_rd_ff;
   logic                   band_rd_vld_ff;

   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [LUMA_W-1:0] luma_now;
   logic [DIM_W-1:0]  accx_add, accx_fold, accy_add, accy_fold;
   logic              accx_carry, accy_carry;
   logic [CX_W-1:0]   row_raddr;
   logic [PREV_AW-1:0] prev_addr;
   logic [CELL_W-1:0] band_col, band_addr;
   logic [SUM_W-1:0]  rd_sum, new_sum;
   logic [CNT_W-1:0]  rd_cnt, new_cnt;
   logic [BE_W-1:0]   be_cur, be_new;
   logic [LUMA_W-1:0] grid_val, diff;
   logic [EN_W-1:0]   cell_val;
   logic              div_start, div_busy, div_done;
   logic [DIVN_W-1:0] div_num, div_quo;
   logic [CNT_W-1:0]  div_den;
   logic              rsp_band_load;
   logic [FSUM_W-1:0] fsum_rnd;
   logic [FPROD_W-1:0] fmean_prod;
   logic [EN_W-1:0]   frame_mean;

   assign w_eff = eff_dim(width_ff);
   assign h_eff = eff_dim(height_ff);

   assign luma_now = LUMA_W'(req_red) * W_RED + LUMA_W'(req_green) * W_GREEN
                   + LUMA_W'(req_blue) * W_BLUE;

   // Grid coordinates advance as a quotient and remainder: x * LW = cx * w + accx.
   assign accx_add   = DIM_W'(accx_ff) + DIM_W'(LW);
   assign accx_carry = accx_add >= w_eff;
   assign accx_fold  = accx_carry ? accx_add - w_eff : accx_add;
   assign accy_add   = DIM_W'(accy_ff) + DIM_W'(LH);
   assign accy_carry = accy_add >= h_eff;
   assign accy_fold  = accy_carry ? accy_add - h_eff : accy_add;

   assign restart = csr_write
                 && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT);

   assign row_raddr = cmd.accept ? cx_ff : gcol_ff;
   assign prev_addr = PREV_AW'(int'(g_ff) * LW + int'(gcol_ff));
   assign band_col  = CELL_W'(gcol_ff >> CSUB_W);
   assign band_addr = cmd.band_read ? c_ff : band_col;

   assign rd_sum  = row_rd_vld_ff ? row_rd_ff[SUM_W+CNT_W-1:CNT_W] : '0;
   assign rd_cnt  = row_rd_vld_ff ? row_rd_ff[CNT_W-1:0] : '0;
   assign new_sum = rd_sum + SUM_W'(luma_ff);
   assign new_cnt = rd_cnt + 1'b1;

   assign be_cur   = band_rd_vld_ff ? band_rd_ff : '0;
   assign grid_val = (rd_cnt == '0) ? '0
                   : ((div_quo > DIVN_W'(16'hFFFF)) ? 16'hFFFF : div_quo[LUMA_W-1:0]);
   assign diff     = (grid_val > prev_rd_ff) ? grid_val - prev_rd_ff : prev_rd_ff - grid_val;
   assign be_new   = have_prev_ff ? be_cur + BE_W'(diff) : be_cur;
   assign cell_val = EN_W'((be_cur + BE_W'(AREA / 2)) >> (2 * CSUB_W));

   // The frame mean, rounded to nearest: a shift by six bits (a division by 64) and a multiplication by one third.
   assign fsum_rnd   = frame_sum_ff + FSUM_W'(NCELLS / 2);
   assign fmean_prod = FPROD_W'(fsum_rnd[FSUM_W-1:FMEAN_SH]) * FPROD_W'(THIRD_RECIP);
   assign frame_mean = fmean_prod[THIRD_SHIFT+EN_W-1:THIRD_SHIFT];

   // The divider forms the grid averages, rounded to nearest.
   assign div_start = cmd.div_row_start;
   assign div_num   = DIVN_W'(rd_sum) + DIVN_W'(rd_cnt >> 1);
   assign div_den   = rd_cnt;

   cme_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_band_load = cmd.band_commit && stat.emit_band;

   always_comb begin
      stat.row_end     = {1'b0, x_ff} == w_eff - 1'b1;
      stat.last_row    = {1'b0, y_ff} == h_eff - 1'b1;
      stat.x_fold_more = accx_fold >= w_eff;
      stat.x_more      = DIM_W'(accx_ff) >= w_eff;
      stat.y_fold_more = accy_fold >= h_eff;
      stat.y_more      = DIM_W'(nacc_ff) >= h_eff;
      stat.fin_needed  = gnext_ff > cy_ff;
      stat.cnt_zero    = rd_cnt == '0;
      stat.div_busy    = div_busy;
      stat.div_done    = div_done;
      stat.col_last    = gcol_ff == CX_W'(LW - 1);
      stat.band_end    = (int'(g_ff) % CELL_SIDE) == CELL_SIDE - 1;
      stat.g_last      = (int'(g_ff) + 1) == int'(gnext_ff);
      stat.emit_band   = have_prev_ff && ((int'(g_ff) + CELL_SIDE) >= int'(gnext_ff));
      stat.c_last      = c_ff == CELL_W'(GRID_W - 1);
      stat.frame_out   = fe_ff && have_prev_ff;
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cx_in        = cx_ff;
      gcol_in      = gcol_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      nacc_in      = nacc_ff;
      cy_in        = cy_ff;
      gnext_in     = gnext_ff;
      g_in         = g_ff;
      c_in         = c_ff;
      fe_in        = fe_ff;
      have_prev_in = have_prev_ff;
      frame_sum_in = frame_sum_ff;
      row_vld_in   = row_vld_ff;
      band_vld_in  = band_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.acc_write) begin
         row_vld_in[cx_ff] = 1'b1;
         if (!stat.row_end) begin
            x_in    = x_ff + 1'b1;
            accx_in = ACC_W'(accx_fold);
            cx_in   = cx_ff + CX_W'(accx_carry);
         end else begin
            x_in    = '0;
            accx_in = '0;
            cx_in   = '0;
            g_in    = cy_ff;
            gcol_in = '0;
            c_in    = '0;
            if (stat.last_row) begin
               fe_in    = 1'b1;
               y_in     = '0;
               gnext_in = CY_W'(LH);
               nacc_in  = '0;
            end else begin
               fe_in    = 1'b0;
               y_in     = y_ff + 1'b1;
               nacc_in  = ACC_W'(accy_fold);
               gnext_in = cy_ff + CY_W'(accy_carry);
            end
         end
      end

      if (cmd.x_step) begin
         accx_in = ACC_W'(DIM_W'(accx_ff) - w_eff);
         cx_in   = cx_ff + 1'b1;
      end

      if (cmd.y_step) begin
         nacc_in  = ACC_W'(DIM_W'(nacc_ff) - h_eff);
         gnext_in = gnext_ff + 1'b1;
      end

      if (cmd.fin_write) begin
         row_vld_in[gcol_ff]   = 1'b0;
         band_vld_in[band_col] = 1'b1;
         gcol_in               = gcol_ff + 1'b1;
         if (stat.col_last && !stat.band_end) g_in = g_ff + 1'b1;
      end

      if (cmd.band_commit) begin
         frame_sum_in      = frame_sum_ff + FSUM_W'(cell_val);
         band_vld_in[c_ff] = 1'b0;
         c_in              = c_ff + 1'b1;
         if (stat.c_last) g_in = g_ff + 1'b1;
      end

      if (rsp_band_load || cmd.frame_load) rsp_valid_in = 1'b1;

      if (cmd.row_commit) begin
         cy_in   = fe_ff ? '0 : gnext_ff;
         accy_in = fe_ff ? '0 : nacc_ff;
         if (fe_ff) begin
            frame_sum_in = '0;
            have_prev_in = 1'b1;
         end
      end

      if (csr_write && csr_index == REG_FRAME_WIDTH) width_in = csr_wdata;
      if (csr_write && csr_index == REG_FRAME_HEIGHT) height_in = csr_wdata;
      if (restart) begin
         x_in         = '0;
         y_in         = '0;
         cx_in        = '0;
         accx_in      = '0;
         cy_in        = '0;
         accy_in      = '0;
         frame_sum_in = '0;
         row_vld_in   = '0;
         band_vld_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RESET_WIDTH;
         height_ff    <= RESET_HEIGHT;
         x_ff         <= '0;
         y_ff         <= '0;
         cx_ff        <= '0;
         gcol_ff      <= '0;
         accx_ff      <= '0;
         accy_ff      <= '0;
         nacc_ff      <= '0;
         cy_ff        <= '0;
         gnext_ff     <= '0;
         g_ff         <= '0;
         c_ff         <= '0;
         fe_ff        <= 1'b0;
         have_prev_ff <= 1'b0;
         frame_sum_ff <= '0;
         row_vld_ff   <= '0;
         band_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         cx_ff        <= cx_in;
         gcol_ff      <= gcol_in;
         accx_ff      <= accx_in;
         accy_ff      <= accy_in;
         nacc_ff      <= nacc_in;
         cy_ff        <= cy_in;
         gnext_ff     <= gnext_in;
         g_ff         <= g_in;
         c_ff         <= c_in;
         fe_ff        <= fe_in;
         have_prev_ff <= have_prev_in;
         frame_sum_ff <= frame_sum_in;
         row_vld_ff   <= row_vld_in;
         band_vld_ff  <= band_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) luma_ff <= luma_now;
      if (rsp_band_load) begin
         rsp_kind_ff   <= KIND_CELL;
         rsp_idx_ff    <= IDX_W'(int'(g_ff) / CELL_SIDE * GRID_W + int'(c_ff));
         rsp_energy_ff <= cell_val;
         rsp_last_ff   <= stat.c_last && !fe_ff;
      end else if (cmd.frame_load) begin
         rsp_kind_ff   <= KIND_FRAME;
         rsp_idx_ff    <= '0;
         rsp_energy_ff <= frame_mean;
         rsp_last_ff   <= 1'b1;
      end
   end

   // Column sums and pixel counts of the grid row being gathered.
   always_ff @(posedge clock) begin
      if (cmd.accept || cmd.fin_read) begin
         row_rd_ff     <= row_mem[row_raddr];
         row_rd_vld_ff <= row_vld_ff[row_raddr];
      end
      if (cmd.acc_write) row_mem[cx_ff] <= {new_sum, new_cnt};
   end

   // Previous frame's grid.
   always_ff @(posedge clock) begin
      if (cmd.fin_read) prev_rd_ff <= prev_mem[prev_addr];
      if (cmd.fin_write) prev_mem[prev_addr] <= grid_val;
   end

   // Per-cell energy of the current band.
   always_ff @(posedge clock) begin
      if (cmd.fin_read || cmd.band_read) begin
         band_rd_ff     <= band_mem[band_addr];
         band_rd_vld_ff <= band_vld_ff[band_addr];
      end
      if (cmd.fin_write) band_mem[band_col] <= be_new;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_cell_index = rsp_idx_ff;
   assign rsp_energy     = rsp_energy_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ hdl/cme_ctrl.sv @@
// Controller state machine that sequences pixel intake, row finishing and result output.
module cme_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cme_pkg::cme_stat_type  stat,
   output cme_pkg::cme_cmd_type   cmd
);
   import cme_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ACC    = 4'd1;
   localparam logic [3:0] S_XADV   = 4'd2;
   localparam logic [3:0] S_YADV   = 4'd3;
   localparam logic [3:0] S_ROWCHK = 4'd4;
   localparam logic [3:0] S_FRD    = 4'd5;
   localparam logic [3:0] S_FLAT   = 4'd6;
   localparam logic [3:0] S_FDIV   = 4'd7;
   localparam logic [3:0] S_FWR    = 4'd8;
   localparam logic [3:0] S_BRD    = 4'd9;
   localparam logic [3:0] S_BCALC  = 4'd10;
   localparam logic [3:0] S_END    = 4'd11;
   localparam logic [3:0] S_FOUT   = 4'd13;
   localparam logic [3:0] S_COMMIT = 4'd14;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc_write = 1'b1;
            if (!stat.row_end) state_in = stat.x_fold_more ? S_XADV : S_IDLE;
            else if (stat.last_row) state_in = S_FRD;
            else state_in = stat.y_fold_more ? S_YADV : S_ROWCHK;
         end
         S_XADV: begin
            if (stat.x_more) cmd.x_step = 1'b1;
            else state_in = S_IDLE;
         end
         S_YADV: begin
            if (stat.y_more) cmd.y_step = 1'b1;
            else state_in = S_ROWCHK;
         end
         S_ROWCHK: begin
            state_in = stat.fin_needed ? S_FRD : S_COMMIT;
         end
         S_FRD: begin
            cmd.fin_read = 1'b1;
            state_in     = S_FLAT;
         end
         S_FLAT: begin
            if (stat.cnt_zero) begin
               state_in = S_FWR;
            end else begin
               cmd.div_row_start = 1'b1;
               state_in          = S_FDIV;
            end
         end
         S_FDIV: begin
            if (stat.div_done) state_in = S_FWR;
         end
         S_FWR: begin
            cmd.fin_write = 1'b1;
            if (!stat.col_last) state_in = S_FRD;
            else if (stat.band_end) state_in = S_BRD;
            else state_in = stat.g_last ? S_END : S_FRD;
         end
         S_BRD: begin
            cmd.band_read = 1'b1;
            state_in      = S_BCALC;
         end
         S_BCALC: begin
            if (!stat.emit_band || stat.out_free) begin
               cmd.band_commit = 1'b1;
               if (!stat.c_last) state_in = S_BRD;
               else state_in = stat.g_last ? S_END : S_FRD;
            end
         end
         S_END: begin
            state_in = stat.frame_out ? S_FOUT : S_COMMIT;
         end
         S_FOUT: begin
            if (stat.out_free) begin
               cmd.frame_load = 1'b1;
               state_in       = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.row_commit = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/cell_motion_energy.sv @@
// Top level of the cell motion energy block: controller, datapath and checks.
// A pixel beat is read, then its column sum is updated; a frame narrower than
// 128 pixels can add steps over extra grid columns before the next beat is taken.
// Finishing a grid row sweeps its 128 columns, each read, divided out when it holds pixels
// and written back; at a band end each cell is read and committed, then the frame mean may follow.
// Reset is synchronous: it clears all control state, restores 640 x 448 and needs no sweep.
module cell_motion_energy (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cme_pkg::CH_W-1:0]        req_red,
   input  logic [cme_pkg::CH_W-1:0]        req_green,
   input  logic [cme_pkg::CH_W-1:0]        req_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [cme_pkg::IDX_W-1:0]       rsp_cell_index,
   output logic [cme_pkg::EN_W-1:0]        rsp_energy,
   output logic                            rsp_last,
   input  logic                            csr_write,
   input  logic [cme_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cme_pkg::DIM_W-1:0]       csr_wdata
);
   import cme_pkg::*;

   // The controller and the datapath talk only through these two bundles.
   cme_cmd_type  cmd;
   cme_stat_type stat;

   // The controller takes one pixel beat at a time. After the last pixel of a source
   // row it walks every grid row that the row closes: each column average is divided
   // out, compared with the stored grid point and folded into its cell's energy. At the
   // end of a band the cell energies are rounded, added into the frame sum and, for the
   // last band closed by the row, sent out as result beats.
   cme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath owns the column sum memory, the previous grid store, the band
   // energies, the divider and the output register, so a finished result can
   // wait for the consumer while the controller keeps working on the rest of the band.
   cme_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_cell_index (rsp_cell_index),
      .rsp_energy     (rsp_energy),
      .rsp_last       (rsp_last)
   );

   // Only one pixel is in flight: after a beat is taken the input stalls.
   a_one_pixel: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("pixel accepted while the previous one was still in work");

   // A result is only loaded when the output register is free or being drained.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.frame_load || (cmd.band_commit && stat.emit_band)) |-> stat.out_free)
      else $error("result register overwritten while a beat was pending");

   // The divider is never restarted while it is still working.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_row_start |-> !stat.div_busy)
      else $error("divider started while busy");

endmodule
